// ===== hdl/brle8_pkg.sv =====
// Shared widths, event codes and register indexes of the RLE8 pixel stream decoder.
package brle8_pkg;

  // Configuration port geometry
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned DimW     = 13;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_IMAGE_WIDTH  = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_IMAGE_HEIGHT = 8'd1;

  // Result payload widths
  localparam int unsigned RowW  = 12;
  localparam int unsigned ColW  = 12;
  localparam int unsigned ByteW = 8;

  // Result event codes
  typedef enum logic [2:0] {
    EV_SPAN    = 3'd0,
    EV_EOL     = 3'd1,
    EV_EOB     = 3'd2,
    EV_DELTA   = 3'd3,
    EV_OUTSIDE = 3'd4
  } event_kind_e;

endpackage

// ===== hdl/brle8_if.sv =====
// Handshake channels of the RLE8 decoder: byte input, event output and register writes.
interface brle8_in_if
  import brle8_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             start_image;

  modport source (output valid, data_byte, start_image, input ready);
  modport sink   (input valid, data_byte, start_image, output ready);
endinterface

interface brle8_out_if
  import brle8_pkg::*;
();
  logic             valid;
  logic             ready;
  event_kind_e      event_kind;
  logic [RowW-1:0]  out_row;
  logic [ColW-1:0]  col_start;
  logic [ByteW-1:0] run_length;
  logic [ByteW-1:0] pixel_index;

  modport source (output valid, event_kind, out_row, col_start, run_length, pixel_index,
                  input ready);
  modport sink   (input valid, event_kind, out_row, col_start, run_length, pixel_index,
                  output ready);
endinterface

interface brle8_cfg_if
  import brle8_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

// ===== hdl/bmp_rle8_decoder.sv =====
// RLE8 pixel stream decoder top level: parser, position tracking and result register.
//
// The decoder takes one compressed byte per clock and gives at most one event per byte,
// registered when the byte is taken: a span (row, first column, length, palette index),
// an end-of-line or end-of-bitmap marker, a delta escape (unsupported, halts) or a span
// that falls outside the image. The byte is decoded by a single level of logic from the
// parser state into one output register, so the sustained rate is one byte per cycle;
// the input stalls only while that output register holds an event that is not taken.
// Width and height registers are always ready and should be written while idle; a
// start_image flag on a byte restarts the parser, line and column before that byte.
module bmp_rle8_decoder
  import brle8_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  brle8_in_if.sink    in_chan,
  brle8_out_if.source out_chan,
  brle8_cfg_if.sink   cfg_chan
);

  typedef enum logic [2:0] {
    PH_COUNT   = 3'd0,
    PH_VALUE   = 3'd1,
    PH_ESCAPE  = 3'd2,
    PH_LITERAL = 3'd3,
    PH_PAD     = 3'd4,
    PH_HALT    = 3'd5
  } phase_e;

  localparam logic [ByteW-1:0] ESC_EOL   = 8'd0;
  localparam logic [ByteW-1:0] ESC_EOB   = 8'd1;
  localparam logic [ByteW-1:0] ESC_DELTA = 8'd2;

  localparam int unsigned  LimW     = 17;
  localparam logic [LimW-1:0] MaxWLim = LimW'(MAX_WIDTH);
  localparam logic [LimW-1:0] MaxHLim = LimW'(MAX_HEIGHT);
  localparam logic [DimW-1:0] ColSat  = DimW'((1 << ColW) - 1);

  // Registers
  logic [DimW-1:0]  img_w_q, img_h_q;
  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] held_q, held_d;
  logic [DimW-1:0]  line_q, line_d;
  logic [DimW-1:0]  col_q, col_d;
  logic             odd_q, odd_d;

  logic             out_valid_q;
  event_kind_e      kind_q, kind_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [ColW-1:0]  cstart_q, cstart_d;
  logic [ByteW-1:0] run_q, run_d;
  logic [ByteW-1:0] pix_q, pix_d;
  logic             emit_d;

  // Handshake
  logic in_acc;
  assign in_chan.ready = !out_valid_q || out_chan.ready;
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= DimW'(1);
      img_h_q <= DimW'(1);
    end else if (cfg_chan.valid) begin
      if (cfg_chan.index == REG_IMAGE_WIDTH) begin
        img_w_q <= cfg_chan.wdata[DimW-1:0];
      end else if (cfg_chan.index == REG_IMAGE_HEIGHT) begin
        img_h_q <= cfg_chan.wdata[DimW-1:0];
      end
    end
  end

  // Clamp the image size to its legal range
  logic [DimW-1:0] eff_w, eff_h;
  always_comb begin
    eff_w = img_w_q;
    if (img_w_q == '0) begin
      eff_w = DimW'(1);
    end else if ({{(LimW-DimW){1'b0}}, img_w_q} > MaxWLim) begin
      eff_w = MaxWLim[DimW-1:0];
    end
    eff_h = img_h_q;
    if (img_h_q == '0) begin
      eff_h = DimW'(1);
    end else if ({{(LimW-DimW){1'b0}}, img_h_q} > MaxHLim) begin
      eff_h = MaxHLim[DimW-1:0];
    end
  end

  // Apply the start flag ahead of the byte
  phase_e           ph_s;
  logic [ByteW-1:0] held_s;
  logic [DimW-1:0]  line_s, col_s;
  logic             odd_s;
  always_comb begin
    ph_s   = phase_q;
    held_s = held_q;
    line_s = line_q;
    col_s  = col_q;
    odd_s  = odd_q;
    if (in_chan.start_image) begin
      ph_s   = PH_COUNT;
      held_s = '0;
      line_s = '0;
      col_s  = '0;
      odd_s  = 1'b0;
    end
  end

  // Row of the current line and span bounds
  logic            line_in;
  logic [DimW-1:0] row_full;
  logic [RowW-1:0] row_cur;
  logic [ByteW-1:0] span_run;
  logic [DimW:0]   span_end;
  logic            span_in;
  logic [DimW-1:0] span_col_nxt;
  logic [ColW-1:0] span_col;
  always_comb begin
    line_in  = line_s < eff_h;
    row_full = eff_h - DimW'(1) - line_s;
    row_cur  = line_in ? row_full[RowW-1:0] : '0;
    span_run = (ph_s == PH_LITERAL) ? ByteW'(1) : held_s;
    span_end = {1'b0, col_s} + (DimW+1)'(span_run);
    span_in  = line_in && (span_end <= {1'b0, eff_w});
    span_col_nxt = (span_end > {1'b0, eff_w}) ? eff_w : span_end[DimW-1:0];
    span_col = (col_s > ColSat) ? ColSat[ColW-1:0] : col_s[ColW-1:0];
  end

  // Decode one byte
  logic [ByteW-1:0] held_dec;
  always_comb begin
    phase_d  = ph_s;
    held_d   = held_s;
    line_d   = line_s;
    col_d    = col_s;
    odd_d    = odd_s;
    emit_d   = 1'b0;
    kind_d   = EV_SPAN;
    row_d    = row_cur;
    cstart_d = '0;
    run_d    = '0;
    pix_d    = '0;
    held_dec = held_s - ByteW'(1);
    unique case (ph_s)
      PH_COUNT: begin
        if (in_chan.data_byte != '0) begin
          held_d  = in_chan.data_byte;
          phase_d = PH_VALUE;
        end else begin
          phase_d = PH_ESCAPE;
        end
      end
      PH_VALUE: begin
        emit_d   = 1'b1;
        kind_d   = span_in ? EV_SPAN : EV_OUTSIDE;
        cstart_d = span_col;
        run_d    = span_run;
        pix_d    = in_chan.data_byte;
        col_d    = span_col_nxt;
        held_d   = '0;
        phase_d  = PH_COUNT;
      end
      PH_ESCAPE: begin
        if (in_chan.data_byte == ESC_EOL) begin
          emit_d  = 1'b1;
          kind_d  = EV_EOL;
          col_d   = '0;
          line_d  = line_in ? line_s + DimW'(1) : line_s;
          phase_d = PH_COUNT;
        end else if (in_chan.data_byte == ESC_EOB) begin
          emit_d  = 1'b1;
          kind_d  = EV_EOB;
          line_d  = line_in ? line_s + DimW'(1) : line_s;
          phase_d = PH_HALT;
        end else if (in_chan.data_byte == ESC_DELTA) begin
          emit_d  = 1'b1;
          kind_d  = EV_DELTA;
          phase_d = PH_HALT;
        end else begin
          held_d  = in_chan.data_byte;
          odd_d   = in_chan.data_byte[0];
          phase_d = PH_LITERAL;
        end
      end
      PH_LITERAL: begin
        emit_d   = 1'b1;
        kind_d   = span_in ? EV_SPAN : EV_OUTSIDE;
        cstart_d = span_col;
        run_d    = span_run;
        pix_d    = in_chan.data_byte;
        col_d    = span_col_nxt;
        held_d   = held_dec;
        if (held_dec == '0) begin
          phase_d = odd_s ? PH_PAD : PH_COUNT;
          odd_d   = 1'b0;
        end
      end
      PH_PAD: begin
        phase_d = PH_COUNT;
      end
      default: begin
        phase_d = PH_HALT;
      end
    endcase
  end

  // Advance parser state and load the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_COUNT;
      held_q      <= '0;
      line_q      <= '0;
      col_q       <= '0;
      odd_q       <= 1'b0;
      out_valid_q <= 1'b0;
      kind_q      <= EV_SPAN;
      row_q       <= '0;
      cstart_q    <= '0;
      run_q       <= '0;
      pix_q       <= '0;
    end else begin
      if (in_acc) begin
        phase_q     <= phase_d;
        held_q      <= held_d;
        line_q      <= line_d;
        col_q       <= col_d;
        odd_q       <= odd_d;
        out_valid_q <= emit_d;
        if (emit_d) begin
          kind_q   <= kind_d;
          row_q    <= row_d;
          cstart_q <= cstart_d;
          run_q    <= run_d;
          pix_q    <= pix_d;
        end
      end else if (out_chan.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_chan.valid       = out_valid_q;
  assign out_chan.event_kind  = kind_q;
  assign out_chan.out_row     = row_q;
  assign out_chan.col_start   = cstart_q;
  assign out_chan.run_length  = run_q;
  assign out_chan.pixel_index = pix_q;

  // Hold the input while a result waits
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_chan.ready) |-> !in_chan.ready)
    else $error("input taken while result stalled");

  // Bytes in the count, pad and halt phases leave the output empty
  a_silent_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !in_chan.start_image &&
     (phase_q == PH_COUNT || phase_q == PH_PAD || phase_q == PH_HALT)) |=> !out_valid_q)
    else $error("result from a silent byte");

  // Markers carry no span
  a_marker_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (kind_q == EV_EOL || kind_q == EV_EOB || kind_q == EV_DELTA))
      |-> (run_q == '0 && cstart_q == '0 && pix_q == '0))
    else $error("marker with span payload");

  // Spans always cover at least one pixel
  a_span_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (kind_q == EV_SPAN || kind_q == EV_OUTSIDE)) |-> run_q != '0)
    else $error("empty span reported");

endmodule
